// ----- hdl/btt_pkg.sv -----
package btt_pkg;

	localparam int ELEMENT_BYTES = 4;
	localparam int BUF_PITCH = 16 + 4 / ELEMENT_BYTES;

	localparam int IN_BYTES_W = 40;
	localparam int OUT_BYTES_W = 224;

	typedef enum logic [3:0] {
		REG_HEIGHT      = 4'd0,
		REG_WIDTH       = 4'd1,
		REG_MAGIC_ROWS  = 4'd2,
		REG_SHIFT_ROWS  = 4'd3,
		REG_MAGIC_COLS  = 4'd4,
		REG_SHIFT_COLS  = 4'd5,
		REG_TILE_STRIDE = 4'd6,
		REG_TILE_TOTAL  = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [23:0] height;
		logic [23:0] width;
		logic [31:0] magic_rows;
		logic [4:0]  shift_rows;
		logic [31:0] magic_cols;
		logic [4:0]  shift_cols;
		logic [15:0] tile_stride;
		logic [31:0] tile_total;
		logic [20:0] rows_t;
		logic [20:0] cols_t;
		logic [47:0] hw;
	} cfg_t;

	typedef struct packed {
		logic        active;
		logic [31:0] bat;
		logic [31:0] q1;
		logic [31:0] col;
		logic [7:0]  lane;
	} split_t;

	typedef struct packed {
		logic        tile_active;
		logic [31:0] batch_index;
		logic [19:0] tile_row;
		logic [19:0] tile_col;
		logic [63:0] src_addr;
		logic        src_valid;
		logic [63:0] dst_addr;
		logic        dst_valid;
		logic [8:0]  buffer_write_slot;
		logic [8:0]  buffer_read_slot;
	} result_t;

	function automatic logic [8:0] slot_of(input logic [3:0] major, input logic [3:0] minor);
		logic [8:0] r;
		r = 9'(BUF_PITCH) * {5'b0, major} + {5'b0, minor};
		return r;
	endfunction

endpackage

// ----- hdl/btt_cfg.sv -----
module btt_cfg
	import btt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	logic [23:0] height_q;
	logic [23:0] width_q;
	logic [31:0] magic_rows_q;
	logic [4:0]  shift_rows_q;
	logic [31:0] magic_cols_q;
	logic [4:0]  shift_cols_q;
	logic [15:0] tile_stride_q;
	logic [31:0] tile_total_q;
	logic [20:0] rows_t_q;
	logic [20:0] cols_t_q;
	logic [47:0] hw_q;
	logic [24:0] rows_sum;
	logic [24:0] cols_sum;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q      <= 24'd1;
			width_q       <= 24'd1;
			magic_rows_q  <= '0;
			shift_rows_q  <= '0;
			magic_cols_q  <= '0;
			shift_cols_q  <= '0;
			tile_stride_q <= 16'd1;
			tile_total_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEIGHT:      height_q      <= cfg_data[23:0];
				REG_WIDTH:       width_q       <= cfg_data[23:0];
				REG_MAGIC_ROWS:  magic_rows_q  <= cfg_data;
				REG_SHIFT_ROWS:  shift_rows_q  <= cfg_data[4:0];
				REG_MAGIC_COLS:  magic_cols_q  <= cfg_data;
				REG_SHIFT_COLS:  shift_cols_q  <= cfg_data[4:0];
				REG_TILE_STRIDE: tile_stride_q <= cfg_data[15:0];
				REG_TILE_TOTAL:  tile_total_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rows_sum = {1'b0, height_q} + 25'd15;
	assign cols_sum = {1'b0, width_q} + 25'd15;

	// derived terms follow the registers in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_t_q <= 21'd1;
			cols_t_q <= 21'd1;
			hw_q     <= 48'd1;
		end else begin
			rows_t_q <= rows_sum[24:4];
			cols_t_q <= cols_sum[24:4];
			hw_q     <= {24'b0, height_q} * {24'b0, width_q};
		end
	end

	always_comb begin
		cfg.height      = height_q;
		cfg.width       = width_q;
		cfg.magic_rows  = magic_rows_q;
		cfg.shift_rows  = shift_rows_q;
		cfg.magic_cols  = magic_cols_q;
		cfg.shift_cols  = shift_cols_q;
		cfg.tile_stride = tile_stride_q;
		cfg.tile_total  = tile_total_q;
		cfg.rows_t      = rows_t_q;
		cfg.cols_t      = cols_t_q;
		cfg.hw          = hw_q;
	end

endmodule

// ----- hdl/btt_split.sv -----
module btt_split
	import btt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] block_number,
	input  logic [15:0] pass_number,
	input  logic [7:0]  lane,
	output logic        out_valid,
	input  logic        out_ready,
	output split_t      out_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic [31:0] id_s1, id_s2, id_s3, id_s4;
	logic [7:0]  lane_s1, lane_s2, lane_s3, lane_s4, lane_s5;
	logic [63:0] p1_s2;
	logic        active_s2, active_s3, active_s4, active_s5;
	logic [31:0] q1_s3, q1_s4, q1_s5;
	logic [31:0] m1_s4;
	logic [63:0] p2_s4;
	logic [31:0] col_s5;
	logic [31:0] bat_s5;
	logic [31:0] step;
	logic [31:0] q1_sum;
	logic [31:0] bat_sum;

	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	assign step    = {16'b0, pass_number} * {16'b0, cfg.tile_stride};
	assign q1_sum  = p1_s2[63:32] + id_s2;
	assign bat_sum = p2_s4[63:32] + q1_s4;

	always_ff @(posedge clk) begin
		if (en1) begin
			id_s1   <= {16'b0, block_number} + step;
			lane_s1 <= lane;
		end
		if (en2) begin
			p1_s2     <= {32'b0, id_s1} * {32'b0, cfg.magic_cols};
			active_s2 <= id_s1 < cfg.tile_total;
			id_s2     <= id_s1;
			lane_s2   <= lane_s1;
		end
		if (en3) begin
			q1_s3     <= q1_sum >> cfg.shift_cols;
			id_s3     <= id_s2;
			active_s3 <= active_s2;
			lane_s3   <= lane_s2;
		end
		if (en4) begin
			m1_s4     <= q1_s3 * {11'b0, cfg.cols_t};
			p2_s4     <= {32'b0, q1_s3} * {32'b0, cfg.magic_rows};
			q1_s4     <= q1_s3;
			id_s4     <= id_s3;
			active_s4 <= active_s3;
			lane_s4   <= lane_s3;
		end
		if (en5) begin
			col_s5    <= id_s4 - m1_s4;
			bat_s5    <= bat_sum >> cfg.shift_rows;
			q1_s5     <= q1_s4;
			active_s5 <= active_s4;
			lane_s5   <= lane_s4;
		end
	end

	assign out_valid       = v_s5;
	assign out_data.active = active_s5;
	assign out_data.bat    = bat_s5;
	assign out_data.q1     = q1_s5;
	assign out_data.col    = col_s5;
	assign out_data.lane   = lane_s5;

`ifndef SYNTHESIS
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready))
		else $error("input blocked while the split pipeline has a bubble");
`endif

endmodule

// ----- hdl/btt_addr.sv -----
module btt_addr
	import btt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  split_t  in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic v_s6, v_s7, v_s8, v_s9, v_s10;
	logic en6, en7, en8, en9, en10;

	logic        active_s6, active_s7, active_s8, active_s9;
	logic [31:0] bat_s6, bat_s7, bat_s8, bat_s9;
	logic [31:0] q1_s6;
	logic [31:0] col_s6, col_s7, col_s8, col_s9;
	logic [7:0]  lane_s6, lane_s7, lane_s8, lane_s9;
	logic [31:0] m2_s6;
	logic [55:0] pa_s6;
	logic [39:0] pb_s6;
	logic [31:0] row_s7, row_s8, row_s9;
	logic [63:0] plane_s7, plane_s8, plane_s9;
	logic [31:0] s_w_s7, s_w_s8, s_w_s9;
	logic [31:0] d_w_s7, d_w_s8;
	logic [31:0] s_h_s8;
	logic [31:0] d_h_s8, d_h_s9;
	logic        sw_ok_s8, dw_ok_s8;
	logic [55:0] ps_s9, pd_s9;
	logic        sv_s9, dv_s9;
	result_t     res_s10;
	logic [31:0] base_c;
	logic [31:0] base_r;

	assign en10 = !v_s10 || out_ready;
	assign en9  = !v_s9 || en10;
	assign en8  = !v_s8 || en9;
	assign en7  = !v_s7 || en8;
	assign en6  = !v_s6 || en7;
	assign in_ready = en6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en6)  v_s6  <= in_valid;
			if (en7)  v_s7  <= v_s6;
			if (en8)  v_s8  <= v_s7;
			if (en9)  v_s9  <= v_s8;
			if (en10) v_s10 <= v_s9;
		end
	end

	assign base_c = {col_s6[27:0], 4'b0};
	assign base_r = {row_s7[27:0], 4'b0};

	always_ff @(posedge clk) begin
		if (en6) begin
			m2_s6     <= in_data.bat * {11'b0, cfg.rows_t};
			pa_s6     <= {24'b0, in_data.bat} * {32'b0, cfg.hw[23:0]};
			pb_s6     <= {8'b0, in_data.bat} * {16'b0, cfg.hw[47:24]};
			active_s6 <= in_data.active;
			bat_s6    <= in_data.bat;
			q1_s6     <= in_data.q1;
			col_s6    <= in_data.col;
			lane_s6   <= in_data.lane;
		end
		if (en7) begin
			row_s7    <= q1_s6 - m2_s6;
			plane_s7  <= {8'b0, pa_s6} + {pb_s6, 24'b0};
			s_w_s7    <= base_c + {28'b0, lane_s6[3:0]};
			d_w_s7    <= base_c + {28'b0, lane_s6[7:4]};
			active_s7 <= active_s6;
			bat_s7    <= bat_s6;
			col_s7    <= col_s6;
			lane_s7   <= lane_s6;
		end
		if (en8) begin
			s_h_s8    <= base_r + {28'b0, lane_s7[7:4]};
			d_h_s8    <= base_r + {28'b0, lane_s7[3:0]};
			sw_ok_s8  <= s_w_s7 < {8'b0, cfg.width};
			dw_ok_s8  <= d_w_s7 < {8'b0, cfg.width};
			s_w_s8    <= s_w_s7;
			d_w_s8    <= d_w_s7;
			plane_s8  <= plane_s7;
			row_s8    <= row_s7;
			active_s8 <= active_s7;
			bat_s8    <= bat_s7;
			col_s8    <= col_s7;
			lane_s8   <= lane_s7;
		end
		if (en9) begin
			ps_s9     <= {24'b0, s_h_s8} * {32'b0, cfg.width};
			pd_s9     <= {24'b0, d_w_s8} * {32'b0, cfg.height};
			sv_s9     <= active_s8 && sw_ok_s8 && (s_h_s8 < {8'b0, cfg.height});
			dv_s9     <= active_s8 && dw_ok_s8 && (d_h_s8 < {8'b0, cfg.height});
			s_w_s9    <= s_w_s8;
			d_h_s9    <= d_h_s8;
			plane_s9  <= plane_s8;
			row_s9    <= row_s8;
			active_s9 <= active_s8;
			bat_s9    <= bat_s8;
			col_s9    <= col_s8;
			lane_s9   <= lane_s8;
		end
		if (en10) begin
			res_s10.tile_active       <= active_s9;
			res_s10.batch_index       <= bat_s9;
			res_s10.tile_row          <= row_s9[19:0];
			res_s10.tile_col          <= col_s9[19:0];
			res_s10.src_addr          <= plane_s9 + {8'b0, ps_s9} + {32'b0, s_w_s9};
			res_s10.src_valid         <= sv_s9;
			res_s10.dst_addr          <= plane_s9 + {8'b0, pd_s9} + {32'b0, d_h_s9};
			res_s10.dst_valid         <= dv_s9;
			res_s10.buffer_write_slot <= slot_of(lane_s9[7:4], lane_s9[3:0]);
			res_s10.buffer_read_slot  <= slot_of(lane_s9[3:0], lane_s9[7:4]);
		end
	end

	assign out_valid = v_s10;
	assign out_data  = res_s10;

`ifndef SYNTHESIS
	a_flags_need_active: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 |-> ((!res_s10.src_valid && !res_s10.dst_valid) || res_s10.tile_active))
		else $error("in-bounds flag set on an inactive tile");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 |-> (res_s10.buffer_write_slot <= 9'(15 * BUF_PITCH + 15)
			&& res_s10.buffer_read_slot <= 9'(15 * BUF_PITCH + 15)))
		else $error("tile buffer slot beyond the padded tile");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s10 && !out_ready && v_s9) |=> (v_s10 && v_s9 && $stable(res_s10.src_addr)
			&& $stable(sv_s9)))
		else $error("stalled request moved inside the address pipeline");
`endif

endmodule

// ----- hdl/batched_tile_transpose_addressing_core.sv -----
// Takes one request per cycle while m_axis_tready holds high; the pipeline has
// ten register stages (s1 to s10) between s_axis and m_axis.
// Backpressure collapses bubbles stage by stage; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) empties the pipeline and loads register defaults.
module batched_tile_transpose_addressing_core
	import btt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// block_number[15:0], pass_number[31:16], lane[39:32]
	input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tile_active[0], batch_index[32:1], tile_row[52:33], tile_col[72:53],
	// src_addr[136:73], src_valid[137], dst_addr[201:138], dst_valid[202],
	// buffer_write_slot[211:203], buffer_read_slot[220:212], zero[223:221]
	output logic [OUT_BYTES_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [3:0]             cfg_index,
	input  logic [31:0]            cfg_data
);

	cfg_t    cfg;
	logic    mid_valid;
	logic    mid_ready;
	split_t  mid_data;
	result_t res;

	btt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	btt_split u_split (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.block_number (s_axis_tdata[15:0]),
		.pass_number  (s_axis_tdata[31:16]),
		.lane         (s_axis_tdata[39:32]),
		.out_valid    (mid_valid),
		.out_ready    (mid_ready),
		.out_data     (mid_data)
	);

	btt_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = {3'b0, res.buffer_read_slot, res.buffer_write_slot,
		res.dst_valid, res.dst_addr, res.src_valid, res.src_addr,
		res.tile_col, res.tile_row, res.batch_index, res.tile_active};

endmodule
